// File: rtl/core/gccg_pkg.sv
// shared types, constants and corner tables of the grid cell connectivity generator
`default_nettype none
package gccg_pkg;

	// field widths
	localparam int unsigned IDX_W   = 30;
	localparam int unsigned VPE_W   = 11;
	localparam int unsigned NV2_W   = 2 * VPE_W;
	localparam int unsigned VNUM_W  = 31;
	localparam int unsigned SUB_W   = 3;
	localparam int unsigned SLOT_W  = 3;
	localparam int unsigned RES_W   = 5;
	localparam int unsigned CODE_W  = 3;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CIDX_W  = 1;

	localparam int unsigned DEF_MAX_EDGE_VERTICES = 1024;

	// divider: quotient bits retired per cycle
	localparam int unsigned DIV_BITS  = 5;
	localparam int unsigned DIV_STEPS = IDX_W / DIV_BITS;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// job queue between front and back, depth must be a power of two
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_VPE  = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_KIND = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_HEXA  = 2'd0,
		KIND_PRISM = 2'd1,
		KIND_TETRA = 2'd2
	} kind_t;

	// one classified cell handed from front to back
	typedef struct packed {
		logic               bad;
		kind_t              kind;
		logic               par;
		logic [VNUM_W-1:0]  base;
		logic [VPE_W-1:0]   nv;
		logic [NV2_W-1:0]   nv2;
	} job_t;

	// corner codes: bit0 +i, bit1 +j, bit2 +k
	localparam logic [CODE_W-1:0] HEXA_CORNERS [8] = '{
		3'd0, 3'd1, 3'd5, 3'd4, 3'd2, 3'd3, 3'd7, 3'd6
	};

	localparam logic [CODE_W-1:0] PRISM_CORNERS [12] = '{
		3'd0, 3'd1, 3'd4, 3'd2, 3'd3, 3'd6,
		3'd1, 3'd5, 3'd4, 3'd3, 3'd7, 3'd6
	};

	localparam logic [CODE_W-1:0] TETRA_EVEN [20] = '{
		3'd0, 3'd1, 3'd2, 3'd4,
		3'd1, 3'd3, 3'd2, 3'd7,
		3'd2, 3'd4, 3'd7, 3'd6,
		3'd1, 3'd4, 3'd5, 3'd7,
		3'd1, 3'd2, 3'd4, 3'd7
	};

	localparam logic [CODE_W-1:0] TETRA_ODD [20] = '{
		3'd0, 3'd3, 3'd2, 3'd6,
		3'd0, 3'd1, 3'd3, 3'd5,
		3'd3, 3'd5, 3'd7, 3'd6,
		3'd5, 3'd4, 3'd6, 3'd0,
		3'd5, 3'd3, 3'd0, 3'd6
	};

	function automatic logic [CODE_W-1:0] corner_code(kind_t kind, logic par,
			logic [RES_W-1:0] r);
		logic [CODE_W-1:0] c;
		c = '0;
		case (kind)
			KIND_HEXA:  c = HEXA_CORNERS[r[2:0]];
			KIND_PRISM: c = PRISM_CORNERS[r[3:0]];
			KIND_TETRA: c = par ? TETRA_ODD[r] : TETRA_EVEN[r];
			default:    c = '0;
		endcase
		return c;
	endfunction

	// index of the last result of a cell
	function automatic logic [RES_W-1:0] last_result(kind_t kind);
		logic [RES_W-1:0] n;
		case (kind)
			KIND_HEXA:  n = 5'd7;
			KIND_PRISM: n = 5'd11;
			KIND_TETRA: n = 5'd19;
			default:    n = '0;
		endcase
		return n;
	endfunction

	// last corner slot of one element
	function automatic logic [SLOT_W-1:0] last_slot(kind_t kind);
		logic [SLOT_W-1:0] n;
		case (kind)
			KIND_HEXA:  n = 3'd7;
			KIND_PRISM: n = 3'd5;
			KIND_TETRA: n = 3'd3;
			default:    n = '0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/grid_cell_connectivity_gen_unit.sv
// top level of the grid cell connectivity generator
// front: a take step, two divisions (load, then six steps of 5 quotient bits each), two
//   multiply steps and a push step that waits while the queue is full; a bad cell skips the
//   remaining steps to the push step, and the input register can hold the next cell meanwhile;
//   back: one vertex item per cycle while out_ready is high, 8, 12 or 20 per cell, one if bad
// reset: asynchronous, active low; vertices_per_edge = 2, element_kind = hexahedron,
//   queue and output empty
`default_nettype none
module grid_cell_connectivity_gen_unit #(
	parameter int unsigned MAX_EDGE_VERTICES = gccg_pkg::DEF_MAX_EDGE_VERTICES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// cell items
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [gccg_pkg::IDX_W-1:0]    cell_index,
	// vertex items
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [gccg_pkg::VNUM_W-1:0]        vertex_number,
	output logic [gccg_pkg::SUB_W-1:0]         sub_element,
	output logic [gccg_pkg::SLOT_W-1:0]        corner_slot,
	output logic                               last_of_cell,
	output logic                               bad_cell,
	// configuration writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [gccg_pkg::CIDX_W-1:0]   cfg_index,
	input  wire logic [gccg_pkg::VPE_W-1:0]    cfg_data
);
	// configuration registers
	logic [gccg_pkg::VPE_W-1:0]  cfg_vpe_q;
	gccg_pkg::kind_t             cfg_kind_q;

	// front to queue
	logic                        push;
	gccg_pkg::job_t              push_job;
	logic                        q_full;
	// queue to back
	gccg_pkg::job_t              head;
	logic                        q_empty;
	logic                        pop;

	// register writes are always taken; the user must write only while the block is idle, it is not enforced
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_vpe_q  <= gccg_pkg::VPE_W'(2);
			cfg_kind_q <= gccg_pkg::KIND_HEXA;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gccg_pkg::CFG_VPE:  cfg_vpe_q  <= cfg_data;
				// the unused kind code is kept so the front can flag every cell bad
				gccg_pkg::CFG_KIND: cfg_kind_q <= gccg_pkg::kind_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// front: input skid register, index split into i j k, base vertex number
	gccg_front #(
		.MAX_EDGE_VERTICES (MAX_EDGE_VERTICES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_index (cell_index),
		.cfg_vpe    (cfg_vpe_q),
		.cfg_kind   (cfg_kind_q),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	// short queue so the front runs ahead while the back is stalled
	gccg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	// back: corner table walk with output register
	gccg_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_empty       (q_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.vertex_number (vertex_number),
		.sub_element   (sub_element),
		.corner_slot   (corner_slot),
		.last_of_cell  (last_of_cell),
		.bad_cell      (bad_cell)
	);
endmodule
`default_nettype wire

// File: rtl/core/gccg_div.sv
// iterative restoring divider, several quotient bits per cycle
`default_nettype none
module gccg_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [gccg_pkg::IDX_W-1:0]    dividend,
	input  wire logic [gccg_pkg::VPE_W-1:0]    divisor,
	output logic                               done,
	output logic [gccg_pkg::IDX_W-1:0]         quot,
	output logic [gccg_pkg::VPE_W-1:0]         rem
);
	localparam int unsigned W  = gccg_pkg::IDX_W;
	localparam int unsigned RW = gccg_pkg::VPE_W;

	logic                             busy_q;
	logic                             done_q;
	logic [gccg_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [W-1:0]                     q_q;
	logic [RW-1:0]                    r_q;
	logic [RW-1:0]                    d_q;
	logic [W-1:0]                     q_nx;
	logic [RW-1:0]                    r_nx;

	// combinational shift-subtract steps, one per quotient bit
	always_comb begin
		logic [RW:0] t;
		q_nx = q_q;
		r_nx = r_q;
		for (int s = 0; s < int'(gccg_pkg::DIV_BITS); s++) begin
			t = {r_nx, q_nx[W-1]};
			q_nx = {q_nx[W-2:0], 1'b0};
			if (t >= {1'b0, d_q}) begin
				t = t - {1'b0, d_q};
				q_nx[0] = 1'b1;
			end
			r_nx = t[RW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			q_q    <= '0;
			r_q    <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				q_q    <= dividend;
				r_q    <= '0;
				d_q    <= divisor;
			end else if (busy_q) begin
				q_q <= q_nx;
				r_q <= r_nx;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == gccg_pkg::DIV_CNT_W'(gccg_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;
endmodule
`default_nettype wire

// File: rtl/core/gccg_queue.sv
// short job queue between front and back
`default_nettype none
module gccg_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire gccg_pkg::job_t   push_job,
	output logic                  full,
	input  wire logic             pop,
	output gccg_pkg::job_t        head,
	output logic                  empty
);
	gccg_pkg::job_t                  entries_q [gccg_pkg::QDEPTH];
	logic [gccg_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [gccg_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [gccg_pkg::QCNT_W-1:0]     cnt_q;

	assign full  = (cnt_q == gccg_pkg::QCNT_W'(gccg_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/gccg_front.sv
// front: takes cell items, splits the index into i j k and forms the base vertex
`default_nettype none
module gccg_front #(
	parameter int unsigned MAX_EDGE_VERTICES = gccg_pkg::DEF_MAX_EDGE_VERTICES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [gccg_pkg::IDX_W-1:0]    cell_index,
	input  wire logic [gccg_pkg::VPE_W-1:0]    cfg_vpe,
	input  wire gccg_pkg::kind_t               cfg_kind,
	output logic                               push,
	output gccg_pkg::job_t                     push_job,
	input  wire logic                          q_full
);
	localparam int unsigned VW  = gccg_pkg::VPE_W;
	localparam int unsigned IW  = gccg_pkg::IDX_W;
	localparam int unsigned NW  = gccg_pkg::NV2_W;
	localparam int unsigned OW  = gccg_pkg::VNUM_W;
	localparam logic [31:0] MAX_V = 32'(MAX_EDGE_VERTICES);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV1, ST_DIV2, ST_MULY, ST_MULZ, ST_SUM
	} state_t;

	state_t              state_q;
	logic                buf_v_q;
	logic [IW-1:0]       buf_idx_q;
	logic                bad_q;
	gccg_pkg::kind_t     kind_q;
	logic [VW-1:0]       nv_q;
	logic [VW-1:0]       nc_q;
	logic [NW-1:0]       nv2_q;
	logic [VW-1:0]       ci_q;
	logic [VW-1:0]       cj_q;
	logic [VW-1:0]       ck_q;
	logic [NW-1:0]       py_q;
	logic [OW-1:0]       pz_q;

	logic [VW-1:0]       nv_eff;
	logic [VW-1:0]       nc_eff;
	logic                cfg_ok;
	logic                take;
	logic                div_start;
	logic [IW-1:0]       div_dividend;
	logic [VW-1:0]       div_divisor;
	logic                div_done;
	logic [IW-1:0]       div_quot;
	logic [VW-1:0]       div_rem;

	always_comb begin
		nv_eff = ({{(32 - VW){1'b0}}, cfg_vpe} > MAX_V) ? VW'(MAX_EDGE_VERTICES) : cfg_vpe;
		nc_eff = (nv_eff >= VW'(2)) ? nv_eff - 1'b1 : '0;
		cfg_ok = (nc_eff != '0) && (cfg_kind == gccg_pkg::KIND_HEXA
			|| cfg_kind == gccg_pkg::KIND_PRISM || cfg_kind == gccg_pkg::KIND_TETRA);
	end

	assign in_ready     = !buf_v_q;
	assign take         = (state_q == ST_IDLE) && buf_v_q;
	assign div_start    = (take && cfg_ok) || ((state_q == ST_DIV1) && div_done);
	assign div_dividend = take ? buf_idx_q : div_quot;
	assign div_divisor  = take ? nc_eff : nc_q;

	gccg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign push = (state_q == ST_SUM) && !q_full;

	always_comb begin
		push_job.bad  = bad_q;
		push_job.kind = kind_q;
		push_job.par  = ci_q[0] ^ cj_q[0] ^ ck_q[0];
		push_job.base = {{(OW - VW){1'b0}}, ci_q} + {{(OW - NW){1'b0}}, py_q}
			+ pz_q + OW'(1);
		push_job.nv   = nv_q;
		push_job.nv2  = nv2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			buf_v_q   <= 1'b0;
			buf_idx_q <= '0;
			bad_q     <= 1'b0;
			kind_q    <= gccg_pkg::KIND_HEXA;
			nv_q      <= '0;
			nc_q      <= '0;
			nv2_q     <= '0;
			ci_q      <= '0;
			cj_q      <= '0;
			ck_q      <= '0;
			py_q      <= '0;
			pz_q      <= '0;
		end else begin
			if (in_valid && in_ready) begin
				buf_v_q   <= 1'b1;
				buf_idx_q <= cell_index;
			end else if (take) begin
				buf_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (buf_v_q) begin
						nv_q   <= nv_eff;
						nc_q   <= nc_eff;
						kind_q <= cfg_kind;
						ci_q   <= '0;
						cj_q   <= '0;
						ck_q   <= '0;
						py_q   <= '0;
						pz_q   <= '0;
						if (cfg_ok) begin
							bad_q   <= 1'b0;
							state_q <= ST_DIV1;
						end else begin
							bad_q   <= 1'b1;
							state_q <= ST_SUM;
						end
					end
				end
				ST_DIV1: begin
					nv2_q <= NW'({{(NW - VW){1'b0}}, nv_q} * {{(NW - VW){1'b0}}, nv_q});
					if (div_done) begin
						ci_q    <= div_rem;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						cj_q <= div_rem;
						ck_q <= div_quot[VW-1:0];
						// k beyond the grid means index past (V-1)^3
						if (div_quot >= {{(IW - VW){1'b0}}, nc_q}) begin
							bad_q   <= 1'b1;
							state_q <= ST_SUM;
						end else begin
							state_q <= ST_MULY;
						end
					end
				end
				ST_MULY: begin
					py_q    <= NW'({{(NW - VW){1'b0}}, cj_q} * {{(NW - VW){1'b0}}, nv_q});
					state_q <= ST_MULZ;
				end
				ST_MULZ: begin
					pz_q    <= OW'({{NW{1'b0}}, ck_q} * {{VW{1'b0}}, nv2_q});
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/gccg_back.sv
// back: walks the corner table of a queued cell, one vertex item per cycle while out_ready is high
`default_nettype none
module gccg_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gccg_pkg::job_t                head,
	input  wire logic                          q_empty,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [gccg_pkg::VNUM_W-1:0]        vertex_number,
	output logic [gccg_pkg::SUB_W-1:0]         sub_element,
	output logic [gccg_pkg::SLOT_W-1:0]        corner_slot,
	output logic                               last_of_cell,
	output logic                               bad_cell
);
	localparam int unsigned OW = gccg_pkg::VNUM_W;
	localparam int unsigned VW = gccg_pkg::VPE_W;
	localparam int unsigned NW = gccg_pkg::NV2_W;

	logic [gccg_pkg::RES_W-1:0]   r_q;
	logic [gccg_pkg::SUB_W-1:0]   sub_q;
	logic [gccg_pkg::SLOT_W-1:0]  slot_q;
	logic                         out_valid_q;
	logic [OW-1:0]                vnum_q;
	logic [gccg_pkg::SUB_W-1:0]   osub_q;
	logic [gccg_pkg::SLOT_W-1:0]  oslot_q;
	logic                         olast_q;
	logic                         obad_q;

	logic                         adv;
	logic                         fire;
	logic                         last;
	logic [gccg_pkg::CODE_W-1:0]  code;
	logic [OW-1:0]                offset;

	assign adv  = !out_valid_q || out_ready;
	assign fire = adv && !q_empty;
	assign last = head.bad || (r_q == gccg_pkg::last_result(head.kind));
	assign pop  = fire && last;

	always_comb begin
		code   = gccg_pkg::corner_code(head.kind, head.par, r_q);
		offset = {{(OW - 1){1'b0}}, code[0]}
			+ (code[1] ? {{(OW - VW){1'b0}}, head.nv} : '0)
			+ (code[2] ? {{(OW - NW){1'b0}}, head.nv2} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			r_q         <= '0;
			sub_q       <= '0;
			slot_q      <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= !q_empty;
			end
			if (fire) begin
				if (last) begin
					r_q    <= '0;
					sub_q  <= '0;
					slot_q <= '0;
				end else begin
					r_q <= r_q + 1'b1;
					if (slot_q == gccg_pkg::last_slot(head.kind)) begin
						slot_q <= '0;
						sub_q  <= sub_q + 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (head.bad) begin
				vnum_q  <= '0;
				osub_q  <= '0;
				oslot_q <= '0;
				olast_q <= 1'b1;
				obad_q  <= 1'b1;
			end else begin
				vnum_q  <= head.base + offset;
				osub_q  <= sub_q;
				oslot_q <= slot_q;
				olast_q <= last;
				obad_q  <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign vertex_number = vnum_q;
	assign sub_element   = osub_q;
	assign corner_slot   = oslot_q;
	assign last_of_cell  = olast_q;
	assign bad_cell      = obad_q;
endmodule
`default_nettype wire

// File: dv/gccg_vertex_checker.sv
// vertex item checker: predicts every cell's vertex items and compares them in order
`default_nettype none
module gccg_vertex_checker #(
	parameter int unsigned MAX_EDGE_VERTICES = gccg_pkg::DEF_MAX_EDGE_VERTICES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [gccg_pkg::IDX_W-1:0]    cell_index,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [gccg_pkg::VNUM_W-1:0]   vertex_number,
	input  wire logic [gccg_pkg::SUB_W-1:0]    sub_element,
	input  wire logic [gccg_pkg::SLOT_W-1:0]   corner_slot,
	input  wire logic                          last_of_cell,
	input  wire logic                          bad_cell,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [gccg_pkg::CIDX_W-1:0]   cfg_index,
	input  wire logic [gccg_pkg::VPE_W-1:0]    cfg_data,
	output int                                 fail_count,
	output int                                 expected_left
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [gccg_pkg::VNUM_W-1:0] vnum;
		logic [gccg_pkg::SUB_W-1:0]  sub;
		logic [gccg_pkg::SLOT_W-1:0] slot;
		logic                        last;
		logic                        bad;
	} vertex_t;

	// corner codes: bit0 +i, bit1 +j, bit2 +k
	localparam logic [2:0] HEXA_ORDER [8] = '{
		3'd0, 3'd1, 3'd5, 3'd4, 3'd2, 3'd3, 3'd7, 3'd6
	};
	localparam logic [2:0] PRISM_ORDER [12] = '{
		3'd0, 3'd1, 3'd4, 3'd2, 3'd3, 3'd6,
		3'd1, 3'd5, 3'd4, 3'd3, 3'd7, 3'd6
	};
	localparam logic [2:0] TET_EVEN_ORDER [20] = '{
		3'd0, 3'd1, 3'd2, 3'd4,  3'd1, 3'd3, 3'd2, 3'd7,
		3'd2, 3'd4, 3'd7, 3'd6,  3'd1, 3'd4, 3'd5, 3'd7,
		3'd1, 3'd2, 3'd4, 3'd7
	};
	localparam logic [2:0] TET_ODD_ORDER [20] = '{
		3'd0, 3'd3, 3'd2, 3'd6,  3'd0, 3'd1, 3'd3, 3'd5,
		3'd3, 3'd5, 3'd7, 3'd6,  3'd5, 3'd4, 3'd6, 3'd0,
		3'd5, 3'd3, 3'd0, 3'd6
	};

	vertex_t                     expected_vertices [$];
	logic [gccg_pkg::VPE_W-1:0]  edge_vertices;
	logic [gccg_pkg::KIND_W-1:0] kind_sel;
	int                          fails = 0;
	int                          pending_n = 0;

	assign fail_count    = fails;
	assign expected_left = pending_n;

	task automatic push_vertex(input longint unsigned vnum, input int sub, input int slot,
			input bit last, input bit bad);
		vertex_t v;
		v.vnum = vnum[gccg_pkg::VNUM_W-1:0];
		v.sub  = sub[gccg_pkg::SUB_W-1:0];
		v.slot = slot[gccg_pkg::SLOT_W-1:0];
		v.last = last;
		v.bad  = bad;
		expected_vertices.push_back(v);
	endtask

	task automatic predict_cell_vertices(input logic [gccg_pkg::IDX_W-1:0] idx);
		longint unsigned nv, nc, ci, cj, ck, x, y, z;
		int count, per_elem;
		bit odd;
		logic [2:0] code;
		nv = (edge_vertices > MAX_EDGE_VERTICES) ? 64'(MAX_EDGE_VERTICES) : 64'(edge_vertices);
		nc = (nv >= 2) ? nv - 1 : 0;
		case (kind_sel)
			gccg_pkg::KIND_HEXA:  begin count = 8;  per_elem = 8; end
			gccg_pkg::KIND_PRISM: begin count = 12; per_elem = 6; end
			gccg_pkg::KIND_TETRA: begin count = 20; per_elem = 4; end
			default:              begin count = 0;  per_elem = 1; end
		endcase
		// empty grid, unknown kind or cell past the grid: one error item
		if (count == 0 || nc == 0 || longint'(idx) >= nc * nc * nc) begin
			push_vertex(0, 0, 0, 1'b1, 1'b1);
			return;
		end
		ci  = idx % nc;
		cj  = (idx / nc) % nc;
		ck  = idx / (nc * nc);
		odd = 1'((ci + cj + ck) % 2);
		for (int r = 0; r < count; r++) begin
			case (kind_sel)
				gccg_pkg::KIND_HEXA:  code = HEXA_ORDER[3'(r)];
				gccg_pkg::KIND_PRISM: code = PRISM_ORDER[4'(r)];
				default:              code = odd ? TET_ODD_ORDER[5'(r)] : TET_EVEN_ORDER[5'(r)];
			endcase
			x = ci + code[0];
			y = cj + code[1];
			z = ck + code[2];
			push_vertex(x + y * nv + z * nv * nv + 1, r / per_elem, r % per_elem,
				r == count - 1, 1'b0);
		end
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		vertex_t want;
		if (!arst_n) begin
			edge_vertices = 11'd2;
			kind_sel      = gccg_pkg::KIND_HEXA;
			pending_n    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_vertices.size() == 0) begin
					$display("%0t: unexpected vertex item, expected none, got vertex %0d bad %0d",
						$time, vertex_number, bad_cell);
					fails++;
				end else begin
					want = expected_vertices.pop_front();
					check_field("vertex_number", want.vnum, vertex_number);
					check_field("sub_element", want.sub, sub_element);
					check_field("corner_slot", want.slot, corner_slot);
					check_field("last_of_cell", want.last, last_of_cell);
					check_field("bad_cell", want.bad, bad_cell);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == gccg_pkg::CFG_VPE)
					edge_vertices = cfg_data;
				else
					kind_sel = cfg_data[gccg_pkg::KIND_W-1:0];
			end
			if (in_valid && in_ready)
				predict_cell_vertices(cell_index);
			pending_n <= expected_vertices.size();
		end
	end

endmodule
`default_nettype wire

// File: dv/testbench.sv
// testbench top: drives cell items and grid settings, stalls the vertex side, gives the verdict
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// kind code that the block must reject
	localparam logic [gccg_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
	// size of the random part, in cell items
	localparam int RANDOM_CELLS = 115;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [gccg_pkg::IDX_W-1:0]    cell_index = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [gccg_pkg::VNUM_W-1:0]   vertex_number;
	logic [gccg_pkg::SUB_W-1:0]    sub_element;
	logic [gccg_pkg::SLOT_W-1:0]   corner_slot;
	logic                          last_of_cell;
	logic                          bad_cell;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [gccg_pkg::CIDX_W-1:0]   cfg_index = '0;
	logic [gccg_pkg::VPE_W-1:0]    cfg_data = '0;

	int fail_count;
	int expected_left;

	// quiet: no idling for the current phase; calm: no idling for the rest of the run
	logic quiet = 1'b0;
	logic calm = 1'b0;
	int   random_sent = 0;
	int   rx_hold = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	grid_cell_connectivity_gen_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cell_index    (cell_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.vertex_number (vertex_number),
		.sub_element   (sub_element),
		.corner_slot   (corner_slot),
		.last_of_cell  (last_of_cell),
		.bad_cell      (bad_cell),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	gccg_vertex_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cell_index    (cell_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.vertex_number (vertex_number),
		.sub_element   (sub_element),
		.corner_slot   (corner_slot),
		.last_of_cell  (last_of_cell),
		.bad_cell      (bad_cell),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	// vertex side: ready drops at random unless the phase is quiet or the run is calm
	always @(posedge clk) begin
		if (calm || quiet) begin
			out_ready <= 1'b1;
		end else if (rx_hold != 0) begin
			rx_hold = rx_hold - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_hold = $urandom_range(0, 15);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// number of cells in the grid, with the edge saturated like the block does
	function automatic longint unsigned cells_in_grid(input logic [gccg_pkg::VPE_W-1:0] vpe);
		longint unsigned nv, nc;
		nv = (vpe > gccg_pkg::DEF_MAX_EDGE_VERTICES) ?
			64'(gccg_pkg::DEF_MAX_EDGE_VERTICES) : 64'(vpe);
		nc = (nv >= 2) ? nv - 1 : 0;
		return nc * nc * nc;
	endfunction

	// one cell item; called right after a rising edge, returns at the edge that takes it
	// valid is left high so the next item can follow without a bubble
	task automatic send_cell(input logic [gccg_pkg::IDX_W-1:0] idx);
		if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cell_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// both registers back to back, only while the block is idle
	task automatic set_grid(input logic [gccg_pkg::VPE_W-1:0] vpe,
			input logic [gccg_pkg::VPE_W-1:0] kind_word);
		cfg_valid <= 1'b1;
		cfg_index <= gccg_pkg::CFG_VPE;
		cfg_data  <= vpe;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= gccg_pkg::CFG_KIND;
		cfg_data  <= kind_word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop sending and wait for every predicted vertex item
	// every cell gives at least one item, so an empty store means the block is idle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0) @(posedge clk);
	endtask

	// one random grid setting followed by a run of cells, mostly inside the grid
	task automatic random_phase(input int n_cells);
		logic [gccg_pkg::VPE_W-1:0] vpe;
		logic [gccg_pkg::KIND_W-1:0] kind;
		logic [gccg_pkg::IDX_W-1:0] idx;
		longint unsigned ncube;
		case ($urandom_range(0, 9))
			0:       vpe = 11'($urandom_range(0, 1));
			1:       vpe = 11'd1024;
			2:       vpe = 11'($urandom_range(1025, 2047));
			3:       vpe = 11'($urandom_range(2, 1024));
			default: vpe = 11'($urandom_range(2, 9));
		endcase
		kind = ($urandom_range(0, 9) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
		// upper data bits are junk the kind register must drop
		set_grid(vpe, {9'($urandom()), kind});
		ncube = cells_in_grid(vpe);
		repeat (n_cells) begin
			case ($urandom_range(0, 9))
				0: idx = 30'($urandom());
				1: idx = (ncube == 0) ? 30'($urandom()) :
					($urandom_range(0, 1) ? 30'(ncube - 1) : 30'(ncube));
				default: idx = (ncube == 0) ? 30'($urandom()) :
					30'($urandom_range(0, int'(ncube - 1)));
			endcase
			send_cell(idx);
			random_sent++;
		end
		settle();
	endtask

	// stimulus
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset grid: 2 vertices per edge, hexahedra, a single cell
		send_cell(30'd0);
		send_cell(30'd1);
		send_cell(30'h3FFF_FFFF);
		settle();

		// tetra: even and odd parity, last cell, first cell past the grid
		set_grid(11'd3, 11'(gccg_pkg::KIND_TETRA));
		send_cell(30'd0);
		send_cell(30'd1);
		send_cell(30'd7);
		send_cell(30'd8);
		settle();

		set_grid(11'd3, 11'(gccg_pkg::KIND_PRISM));
		send_cell(30'd0);
		send_cell(30'd7);
		settle();

		// too few vertices per edge: every cell is an error
		set_grid(11'd0, 11'(gccg_pkg::KIND_HEXA));
		send_cell(30'd0);
		settle();
		set_grid(11'd1, 11'(gccg_pkg::KIND_PRISM));
		send_cell(30'd5);
		settle();

		// largest grid: widest vertex numbers and the grid boundary
		set_grid(11'd1024, 11'(gccg_pkg::KIND_HEXA));
		send_cell(30'd0);
		send_cell(30'd1070599166);
		send_cell(30'd1070599167);
		send_cell(30'h3FFF_FFFF);
		settle();

		// edge above the maximum saturates
		set_grid(11'd2047, 11'(gccg_pkg::KIND_TETRA));
		send_cell(30'd1070599166);
		send_cell(30'd1023);
		settle();

		// unknown element kind
		set_grid(11'd5, {9'h1A5, KIND_NONE});
		send_cell(30'd0);
		send_cell(30'd3);
		settle();

		// random part, some phases without any idling
		while (random_sent < RANDOM_CELLS) begin
			quiet <= ($urandom_range(0, 3) == 0);
			random_phase($urandom_range(8, 20));
		end

		// closing stretch at full rate on both sides
		calm <= 1'b1;
		random_phase(12);

		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_left == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
